// ----- rtl/tcd_pkg.sv -----
// Shared types, constants and helpers for the tone command decider.
`default_nettype none

package tcd_pkg;

    localparam int MAG_W   = 32;
    localparam int CMD_W   = 3;
    localparam int CNT_W   = 4;
    localparam int FRAME_W = 16;
    localparam int NUM_BINS = 5;
    localparam int SCAN_STAGES = NUM_BINS - 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 4;

    // Command codes (bin number equals command code)
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FORWARD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BACKWARD = 3'd4;
    localparam logic [CMD_W-1:0] NO_PICK      = 3'd7;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MAGNITUDE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_MARGIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_PICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_PICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_FRAMES = 3'd4;

    // Config reset values
    localparam logic [MAG_W-1:0]   RST_MIN_MAGNITUDE  = 32'd6000;
    localparam logic [MAG_W-1:0]   RST_WIN_MARGIN     = 32'd1500;
    localparam logic [CNT_W-1:0]   RST_MOVE_PICKS     = 4'd3;
    localparam logic [CNT_W-1:0]   RST_STOP_PICKS     = 4'd8;
    localparam logic [FRAME_W-1:0] RST_STARTUP_FRAMES = 16'd300;

    typedef struct packed {
        logic [MAG_W-1:0]   min_magnitude;
        logic [MAG_W-1:0]   win_margin;
        logic [CNT_W-1:0]   move_picks;
        logic [CNT_W-1:0]   stop_picks;
        logic [FRAME_W-1:0] startup_frames;
    } cfg_t;

    // One scan stage: running best/runner-up plus the frame's bins
    typedef struct packed {
        logic [NUM_BINS-1:0][MAG_W-1:0] mags;
        logic [MAG_W-1:0]               best;
        logic [MAG_W-1:0]               runner;
        logic [CMD_W-1:0]               best_bin;
        logic                           bump;
    } scan_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0] pick;
        logic             bump;
    } entry_t;

    // One step of the best / runner-up scan; a tie never takes the lead
    function automatic scan_t scan_step(scan_t cur, logic [CMD_W-1:0] k);
        scan_t            nxt;
        logic [MAG_W-1:0] m;
        nxt = cur;
        m   = cur.mags[k];
        if (m > cur.best) begin
            nxt.runner   = cur.best;
            nxt.best     = m;
            nxt.best_bin = k;
        end
        else if (m > cur.runner) begin
            nxt.runner = m;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tcd_front.sv -----
// Front end: scan pipeline that finds best/runner-up bins and classifies the frame.
`default_nettype none

module tcd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tcd_pkg::MAG_W-1:0]     mag_stop,
    input  wire logic [tcd_pkg::MAG_W-1:0]     mag_forward,
    input  wire logic [tcd_pkg::MAG_W-1:0]     mag_left,
    input  wire logic [tcd_pkg::MAG_W-1:0]     mag_right,
    input  wire logic [tcd_pkg::MAG_W-1:0]     mag_backward,
    input  wire logic                          bump,
    input  wire logic [tcd_pkg::MAG_W-1:0]     min_magnitude,
    input  wire logic [tcd_pkg::MAG_W-1:0]     win_margin,
    output logic                               push,
    output tcd_pkg::entry_t                    push_data,
    input  wire logic                          queue_full
);

    localparam int STAGES = tcd_pkg::SCAN_STAGES;

    tcd_pkg::scan_t stg_reg  [STAGES];
    tcd_pkg::scan_t stg_next [STAGES];
    tcd_pkg::scan_t src      [STAGES];
    logic [STAGES-1:0] vld_reg;

    tcd_pkg::entry_t pick_reg;
    tcd_pkg::entry_t pick_next;
    logic            pvld_reg;
    logic            adv;
    logic [tcd_pkg::MAG_W-1:0] lead;

    // whole pipeline moves together; only a full queue holds it
    assign adv      = !pvld_reg || !queue_full;
    assign in_stall = !adv;
    assign push     = pvld_reg && adv;
    assign push_data = pick_reg;

    always_comb
    begin
        src[0].mags     = {mag_backward, mag_right, mag_left, mag_forward, mag_stop};
        src[0].best     = mag_stop;
        src[0].runner   = '0;
        src[0].best_bin = tcd_pkg::CMD_STOP;
        src[0].bump     = bump;
        for (int s = 1; s < STAGES; s++)
        begin
            src[s] = stg_reg[s-1];
        end
        for (int s = 0; s < STAGES; s++)
        begin
            stg_next[s] = tcd_pkg::scan_step(src[s], tcd_pkg::CMD_W'(s + 1));
        end
    end

    // decision on the finished scan
    always_comb
    begin
        lead = stg_reg[STAGES-1].best - stg_reg[STAGES-1].runner;
        pick_next.bump = stg_reg[STAGES-1].bump;
        if (stg_reg[STAGES-1].best < min_magnitude || lead < win_margin)
        begin
            pick_next.pick = tcd_pkg::CMD_STOP;
        end
        else
        begin
            pick_next.pick = stg_reg[STAGES-1].best_bin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            pvld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg  <= {vld_reg[STAGES-2:0], in_valid};
            pvld_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
            pick_reg <= pick_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcd_fifo.sv -----
// Short queue between front and back, with a registered head entry.
`default_nettype none

module tcd_fifo #(
    parameter int DEPTH = tcd_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tcd_pkg::entry_t push_data,
    output logic                 full,
    output logic                 head_valid,
    output tcd_pkg::entry_t      head_data,
    input  wire logic            pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcd_pkg::entry_t mem [DEPTH];
    tcd_pkg::entry_t head_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             head_valid_reg, head_valid_next;
    logic             load;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = head_valid_reg;
    assign head_data  = head_reg;
    assign load       = (cnt_reg != '0) && (!head_valid_reg || pop);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (load)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, load})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
        if (load)
        begin
            head_valid_next = 1'b1;
        end
        else if (pop)
        begin
            head_valid_next = 1'b0;
        end
        else
        begin
            head_valid_next = head_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (load)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcd_back.sv -----
// Back end: debounce, startup/bump override and the output register.
`default_nettype none

module tcd_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            head_valid,
    input  wire tcd_pkg::entry_t                 head_data,
    output logic                                 pop,
    input  wire tcd_pkg::cfg_t                   cfg,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [tcd_pkg::CMD_W-1:0]            frame_pick,
    output logic [tcd_pkg::CMD_W-1:0]            stable_command,
    output logic [tcd_pkg::CMD_W-1:0]            drive_command
);

    logic [tcd_pkg::CMD_W-1:0]   committed_reg, committed_next;
    logic [tcd_pkg::CMD_W-1:0]   last_move_reg, last_move_next;
    logic [tcd_pkg::CNT_W-1:0]   move_cnt_reg, move_cnt_next;
    logic [tcd_pkg::CNT_W-1:0]   stop_cnt_reg, stop_cnt_next;
    logic [tcd_pkg::FRAME_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [tcd_pkg::CNT_W-1:0]   cnt_tmp;
    logic [tcd_pkg::CMD_W-1:0]   drive_next;
    logic                        out_valid_reg;
    logic [tcd_pkg::CMD_W-1:0]   pick_out_reg, stable_out_reg, drive_out_reg;

    assign pop            = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid      = out_valid_reg;
    assign frame_pick     = pick_out_reg;
    assign stable_command = stable_out_reg;
    assign drive_command  = drive_out_reg;

    always_comb
    begin
        committed_next = committed_reg;
        last_move_next = last_move_reg;
        move_cnt_next  = move_cnt_reg;
        stop_cnt_next  = stop_cnt_reg;
        cnt_tmp        = '0;

        frame_cnt_next = (frame_cnt_reg < cfg.startup_frames) ?
                         frame_cnt_reg + 1'b1 : frame_cnt_reg;

        if (head_data.pick == tcd_pkg::CMD_STOP)
        begin
            cnt_tmp = (stop_cnt_reg < tcd_pkg::CNT_MAX) ? stop_cnt_reg + 1'b1 : stop_cnt_reg;
            if (cnt_tmp >= cfg.stop_picks)
            begin
                committed_next = tcd_pkg::CMD_STOP;
                stop_cnt_next  = cfg.stop_picks;
            end
            else
            begin
                stop_cnt_next = cnt_tmp;
            end
        end
        else
        begin
            stop_cnt_next = '0;
            if (head_data.pick == last_move_reg)
            begin
                cnt_tmp = (move_cnt_reg < cfg.move_picks) ? move_cnt_reg + 1'b1 : move_cnt_reg;
                move_cnt_next = cnt_tmp;
                if (cnt_tmp >= cfg.move_picks)
                begin
                    committed_next = head_data.pick;
                end
            end
            else
            begin
                last_move_next = head_data.pick;
                move_cnt_next  = tcd_pkg::CNT_W'(1);
            end
        end

        if (frame_cnt_next < cfg.startup_frames || head_data.bump)
        begin
            drive_next = tcd_pkg::CMD_STOP;
        end
        else
        begin
            drive_next = committed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= tcd_pkg::CMD_STOP;
            last_move_reg <= tcd_pkg::NO_PICK;
            move_cnt_reg  <= '0;
            stop_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                committed_reg <= committed_next;
                last_move_reg <= last_move_next;
                move_cnt_reg  <= move_cnt_next;
                stop_cnt_reg  <= stop_cnt_next;
                frame_cnt_reg <= frame_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pick_out_reg   <= head_data.pick;
            stable_out_reg <= committed_next;
            drive_out_reg  <= drive_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tone_command_decider_unit.sv -----
// Top level of the tone command decider: config registers, front, queue, back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  in       | in_valid / in_stall | mag_stop, mag_forward, mag_left, mag_right,
//           |                     | mag_backward, bump
//  out      | out_valid/out_stall | frame_pick, stable_command, drive_command
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle sustained unless a full queue holds the front. From the
// accepting edge to out_valid a request passes the first scan stage, captured at
// the accepting edge, then 3 more scan stages (one bin compare each), the decide
// register, the queue write, the queue head register, and the output register.
// Reset (rst_n, async, low) clears all control state and restores the config
// registers to their defaults; no clearing pass is needed.
// out_stall holds the output register; the queue absorbs the pipe while the
// front keeps taking requests, and in_stall rises only when the queue is full.
// cfg_ready is always high; writes go directly to the register file.
`default_nettype none

module tone_command_decider_unit #(
    parameter int QUEUE_DEPTH = tcd_pkg::QUEUE_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // frame requests
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [tcd_pkg::MAG_W-1:0]           mag_stop,
    input  wire logic [tcd_pkg::MAG_W-1:0]           mag_forward,
    input  wire logic [tcd_pkg::MAG_W-1:0]           mag_left,
    input  wire logic [tcd_pkg::MAG_W-1:0]           mag_right,
    input  wire logic [tcd_pkg::MAG_W-1:0]           mag_backward,
    input  wire logic                                bump,
    // results
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [tcd_pkg::CMD_W-1:0]                frame_pick,
    output logic [tcd_pkg::CMD_W-1:0]                stable_command,
    output logic [tcd_pkg::CMD_W-1:0]                drive_command,
    // config writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tcd_pkg::cfg_t   cfg_reg;
    tcd_pkg::entry_t push_data;
    tcd_pkg::entry_t head_data;
    logic            push;
    logic            queue_full;
    logic            head_valid;
    logic            pop;

    assign cfg_ready = 1'b1;

    // config register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_magnitude  <= tcd_pkg::RST_MIN_MAGNITUDE;
            cfg_reg.win_margin     <= tcd_pkg::RST_WIN_MARGIN;
            cfg_reg.move_picks     <= tcd_pkg::RST_MOVE_PICKS;
            cfg_reg.stop_picks     <= tcd_pkg::RST_STOP_PICKS;
            cfg_reg.startup_frames <= tcd_pkg::RST_STARTUP_FRAMES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcd_pkg::REG_MIN_MAGNITUDE:
                    cfg_reg.min_magnitude  <= cfg_data[tcd_pkg::MAG_W-1:0];
                tcd_pkg::REG_WIN_MARGIN:
                    cfg_reg.win_margin     <= cfg_data[tcd_pkg::MAG_W-1:0];
                tcd_pkg::REG_MOVE_PICKS:
                    cfg_reg.move_picks     <= cfg_data[tcd_pkg::CNT_W-1:0];
                tcd_pkg::REG_STOP_PICKS:
                    cfg_reg.stop_picks     <= cfg_data[tcd_pkg::CNT_W-1:0];
                tcd_pkg::REG_STARTUP_FRAMES:
                    cfg_reg.startup_frames <= cfg_data[tcd_pkg::FRAME_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: scan and classify
    tcd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mag_stop      (mag_stop),
        .mag_forward   (mag_forward),
        .mag_left      (mag_left),
        .mag_right     (mag_right),
        .mag_backward  (mag_backward),
        .bump          (bump),
        .min_magnitude (cfg_reg.min_magnitude),
        .win_margin    (cfg_reg.win_margin),
        .push          (push),
        .push_data     (push_data),
        .queue_full    (queue_full)
    );

    // decoupling queue
    tcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // back: debounce and drive override
    tcd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_data      (head_data),
        .pop            (pop),
        .cfg            (cfg_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_pick     (frame_pick),
        .stable_command (stable_command),
        .drive_command  (drive_command)
    );

endmodule

`default_nettype wire

// ----- rtl/tcd_checker.sv -----
// Port-level checker for the tone command decider, bound to the top level.
`default_nettype none

module tcd_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [tcd_pkg::CMD_W-1:0]      frame_pick,
    input  wire logic [tcd_pkg::CMD_W-1:0]      stable_command,
    input  wire logic [tcd_pkg::CMD_W-1:0]      drive_command,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_pick)
            && $stable(stable_command) && $stable(drive_command))
        else $error("result changed while stalled");

    // drive is either the committed command or the stop override
    a_drive_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_command == tcd_pkg::CMD_STOP
            || drive_command == stable_command)
        else $error("drive command not derived from committed command");

    // only legal command codes appear on frame_pick and stable_command
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_pick <= tcd_pkg::CMD_BACKWARD
            && stable_command <= tcd_pkg::CMD_BACKWARD)
        else $error("illegal command code on output");

    // config writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind tone_command_decider_unit tcd_checker u_tcd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_pick     (frame_pick),
    .stable_command (stable_command),
    .drive_command  (drive_command),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready)
);

`default_nettype wire
